// ----- sv/cnb_pkg.sv -----
// ----------------------------------------------------------------------------
// cnb_pkg
// Shared types, constants and helpers of the categorical naive Bayes block.
// ----------------------------------------------------------------------------
`default_nettype none

package cnb_pkg;

   localparam int CLASS_BITS   = 3;
   localparam int FEAT_BITS    = 4;
   localparam int VAL_BITS     = 4;
   localparam int COUNT_BITS   = 16;
   localparam int NUM_CLASSES  = 8;
   localparam int NUM_VALUES   = 16;
   localparam int DIST_BITS    = 5;
   localparam int SCORE_BITS   = 32;
   localparam int VC_ADDR_BITS = CLASS_BITS + FEAT_BITS + VAL_BITS;
   localparam int DV_ADDR_BITS = CLASS_BITS + FEAT_BITS;
   localparam int LOG_N_BITS   = COUNT_BITS + 1;
   localparam int EXP_BITS     = 5;
   localparam int FRAC_BITS    = 24;
   localparam int LOG_BITS     = EXP_BITS + FRAC_BITS;

   localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
   localparam logic [SCORE_BITS-1:0] LN_FLOOR = 32'shFFF2_2F3B;
   localparam logic [29:0]           LN2_Q30  = 30'd744261118;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_TRAIN   = 2'd1,
      OP_PREDICT = 2'd2,
      OP_NOP     = 2'd3
   } op_type;

   typedef struct packed {
      logic                  start;
      logic [LOG_N_BITS-1:0] num;
      logic [LOG_N_BITS-1:0] den;
   } ln_req_type;

   typedef struct packed {
      logic                         done;
      logic signed [SCORE_BITS-1:0] value;
   } ln_rsp_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      sat_inc = (v == CNT_MAX) ? v : v + COUNT_BITS'(1);
   endfunction

   function automatic logic signed [SCORE_BITS-1:0] sat_add(
      input logic signed [SCORE_BITS-1:0] a,
      input logic signed [SCORE_BITS-1:0] b);
      logic signed [SCORE_BITS:0] s;
      s = {a[SCORE_BITS-1], a} + {b[SCORE_BITS-1], b};
      if (s[SCORE_BITS] != s[SCORE_BITS-1]) begin
         sat_add = s[SCORE_BITS] ? {1'b1, {(SCORE_BITS-1){1'b0}}}
                                 : {1'b0, {(SCORE_BITS-1){1'b1}}};
      end else begin
         sat_add = s[SCORE_BITS-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// ----- sv/cnb_if.sv -----
// ----------------------------------------------------------------------------
// cnb_if
// Request and response channels: valid/ready handshake plus payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface cnb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [2:0] label;
   logic [3:0] feature;
   logic [3:0] value;
   logic       last;
   modport source (output valid, opcode, label, feature, value, last, input ready);
   modport sink   (input valid, opcode, label, feature, value, last, output ready);
endinterface

interface cnb_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  predicted_class;
   logic        found;
   logic [31:0] best_score;
   modport source (output valid, predicted_class, found, best_score, input ready);
   modport sink   (input valid, predicted_class, found, best_score, output ready);
endinterface

`default_nettype wire

// ----- sv/categorical_naive_bayes_top.sv -----
// ----------------------------------------------------------------------------
// categorical_naive_bayes_top
// Categorical naive Bayes classifier: counts in RAM, sequenced scoring.
// ----------------------------------------------------------------------------
// Train: each beat steps through accept, decode, read and write back.
// Predict: after decode, each trained class with a nonzero count is read and
// scored by the shared ln unit (two 24-step log2 runs); a zero count adds a floor
// term and untrained classes are skipped. A last beat then adds the prior of each
// trained class by the same unit and hands over the result once the slot is free.
// Reset and clear run a sweep over all 2048 count RAM words; req ready is low.
`default_nettype none

module categorical_naive_bayes_top
   import cnb_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   cnb_req_if.sink    req_ch,
   cnb_rsp_if.source  rsp_ch
);

   typedef enum logic [3:0] {
      S_SWEEP, S_IDLE, S_DECODE, S_T_RD, S_T_WR, S_P_RD, S_P_DAT,
      S_P_LOG, S_P_ACC, S_Q_LOG, S_Q_WAIT, S_OUT
   } state_type;

   state_type                    state_ff;
   logic [VC_ADDR_BITS-1:0]      sweep_ff;
   op_type                       op_ff;
   logic [CLASS_BITS-1:0]        c_ff;
   logic [FEAT_BITS-1:0]         f_ff;
   logic [VAL_BITS-1:0]          v_ff;
   logic                         last_ff;
   logic [CLASS_BITS-1:0]        k_ff;
   logic signed [SCORE_BITS-1:0] term_ff;
   logic                         found_ff;
   logic [CLASS_BITS-1:0]        best_ff;
   logic signed [SCORE_BITS-1:0] best_score_ff;
   logic [COUNT_BITS-1:0]        cs_ff [NUM_CLASSES];
   logic [COUNT_BITS-1:0]        total_ff;
   logic signed [SCORE_BITS-1:0] score_ff [NUM_CLASSES];
   logic                         rsp_valid_ff;
   logic [CLASS_BITS-1:0]        rsp_class_ff;
   logic                         rsp_found_ff;
   logic [SCORE_BITS-1:0]        rsp_score_ff;

   logic [CLASS_BITS-1:0]        cls;
   logic                         vc_we;
   logic [VC_ADDR_BITS-1:0]      vc_waddr;
   logic [COUNT_BITS-1:0]        vc_wdata;
   logic [COUNT_BITS-1:0]        vc_rdata;
   logic                         dv_we;
   logic [DV_ADDR_BITS-1:0]      dv_waddr;
   logic [DIST_BITS-1:0]         dv_wdata;
   logic [DIST_BITS-1:0]         dv_rdata;
   ln_req_type                   ln_req;
   ln_rsp_type                   ln_rsp;
   logic signed [SCORE_BITS-1:0] post;
   logic                         slot_free;

   assign cls       = (state_ff == S_T_RD || state_ff == S_T_WR) ? c_ff : k_ff;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign post      = sat_add(score_ff[k_ff], ln_rsp.value);

   always_comb begin
      vc_we    = 1'b0;
      vc_waddr = {c_ff, f_ff, v_ff};
      vc_wdata = sat_inc(vc_rdata);
      dv_we    = 1'b0;
      dv_waddr = {c_ff, f_ff};
      dv_wdata = dv_rdata + DIST_BITS'(1);
      ln_req.start = 1'b0;
      ln_req.num   = LOG_N_BITS'(vc_rdata) + LOG_N_BITS'(1);
      ln_req.den   = LOG_N_BITS'(cs_ff[k_ff]) + LOG_N_BITS'(dv_rdata);
      case (state_ff)
         S_SWEEP: begin
            vc_we    = 1'b1;
            vc_waddr = sweep_ff;
            vc_wdata = '0;
            dv_we    = 1'b1;
            dv_waddr = sweep_ff[DV_ADDR_BITS-1:0];
            dv_wdata = '0;
         end
         S_T_WR: begin
            vc_we = 1'b1;
            dv_we = (vc_rdata == '0) && (dv_rdata < DIST_BITS'(NUM_VALUES));
         end
         S_P_DAT: ln_req.start = (vc_rdata != '0);
         S_Q_LOG: begin
            ln_req.start = (cs_ff[k_ff] != '0);
            ln_req.num   = LOG_N_BITS'(cs_ff[k_ff]);
            ln_req.den   = LOG_N_BITS'(total_ff);
         end
         default: ;
      endcase
   end

   cnb_ram #(.ADDR_BITS(VC_ADDR_BITS), .DATA_BITS(COUNT_BITS)) u_vc_ram (
      .clock (clock),
      .we    (vc_we),
      .waddr (vc_waddr),
      .wdata (vc_wdata),
      .raddr ({cls, f_ff, v_ff}),
      .rdata (vc_rdata)
   );

   cnb_ram #(.ADDR_BITS(DV_ADDR_BITS), .DATA_BITS(DIST_BITS)) u_dv_ram (
      .clock (clock),
      .we    (dv_we),
      .waddr (dv_waddr),
      .wdata (dv_wdata),
      .raddr ({cls, f_ff}),
      .rdata (dv_rdata)
   );

   cnb_ln_ratio u_ln (
      .clock (clock),
      .reset (reset),
      .req   (ln_req),
      .rsp   (ln_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            cs_ff[i]    <= '0;
            score_ff[i] <= '0;
         end
      end else begin
         if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_SWEEP: begin
               sweep_ff <= sweep_ff + VC_ADDR_BITS'(1);
               if (sweep_ff == '1) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_ch.valid) begin
                  op_ff    <= op_type'(req_ch.opcode);
                  c_ff     <= req_ch.label;
                  f_ff     <= req_ch.feature;
                  v_ff     <= req_ch.value;
                  last_ff  <= req_ch.last;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               k_ff          <= '0;
               found_ff      <= 1'b0;
               best_ff       <= '0;
               best_score_ff <= '0;
               case (op_ff)
                  OP_CLEAR: begin
                     total_ff <= '0;
                     for (int i = 0; i < NUM_CLASSES; i++) begin
                        cs_ff[i]    <= '0;
                        score_ff[i] <= '0;
                     end
                     sweep_ff <= '0;
                     state_ff <= S_SWEEP;
                  end
                  OP_TRAIN:   state_ff <= S_T_RD;
                  OP_PREDICT: state_ff <= S_P_RD;
                  default:    state_ff <= S_IDLE;
               endcase
            end
            S_T_RD: state_ff <= S_T_WR;
            S_T_WR: begin
               if (last_ff) begin
                  cs_ff[c_ff] <= sat_inc(cs_ff[c_ff]);
                  total_ff    <= sat_inc(total_ff);
               end
               state_ff <= S_IDLE;
            end
            S_P_RD: begin
               if (cs_ff[k_ff] != '0) begin
                  state_ff <= S_P_DAT;
               end else if (k_ff != CLASS_BITS'(NUM_CLASSES - 1)) begin
                  k_ff <= k_ff + CLASS_BITS'(1);
               end else begin
                  k_ff     <= '0;
                  state_ff <= last_ff ? S_Q_LOG : S_IDLE;
               end
            end
            S_P_DAT: begin
               term_ff  <= LN_FLOOR;
               state_ff <= (vc_rdata == '0) ? S_P_ACC : S_P_LOG;
            end
            S_P_LOG: begin
               if (ln_rsp.done) begin
                  term_ff  <= ln_rsp.value;
                  state_ff <= S_P_ACC;
               end
            end
            S_P_ACC: begin
               score_ff[k_ff] <= sat_add(score_ff[k_ff], term_ff);
               if (k_ff != CLASS_BITS'(NUM_CLASSES - 1)) begin
                  k_ff     <= k_ff + CLASS_BITS'(1);
                  state_ff <= S_P_RD;
               end else begin
                  k_ff     <= '0;
                  state_ff <= last_ff ? S_Q_LOG : S_IDLE;
               end
            end
            S_Q_LOG: begin
               if (cs_ff[k_ff] != '0) begin
                  state_ff <= S_Q_WAIT;
               end else if (k_ff != CLASS_BITS'(NUM_CLASSES - 1)) begin
                  k_ff <= k_ff + CLASS_BITS'(1);
               end else begin
                  state_ff <= S_OUT;
               end
            end
            S_Q_WAIT: begin
               if (ln_rsp.done) begin
                  if (!found_ff || post > best_score_ff) begin
                     found_ff      <= 1'b1;
                     best_ff       <= k_ff;
                     best_score_ff <= post;
                  end
                  if (k_ff != CLASS_BITS'(NUM_CLASSES - 1)) begin
                     k_ff     <= k_ff + CLASS_BITS'(1);
                     state_ff <= S_Q_LOG;
                  end else begin
                     state_ff <= S_OUT;
                  end
               end
            end
            S_OUT: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_class_ff <= best_ff;
                  rsp_found_ff <= found_ff;
                  rsp_score_ff <= best_score_ff;
                  for (int i = 0; i < NUM_CLASSES; i++) begin
                     score_ff[i] <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ch.ready           = (state_ff == S_IDLE);
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.predicted_class = rsp_class_ff;
   assign rsp_ch.found           = rsp_found_ff;
   assign rsp_ch.best_score      = rsp_score_ff;

endmodule

`default_nettype wire

// ----- sv/cnb_ram.sv -----
// ----------------------------------------------------------------------------
// cnb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cnb_ram #(
   parameter int ADDR_BITS = 8,
   parameter int DATA_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [ADDR_BITS-1:0] waddr,
   input  wire logic [DATA_BITS-1:0] wdata,
   input  wire logic [ADDR_BITS-1:0] raddr,
   output logic      [DATA_BITS-1:0] rdata
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ----- sv/cnb_ln_ratio.sv -----
// ----------------------------------------------------------------------------
// cnb_ln_ratio
// Iterative ln(num/den) in Q16.16: two log2 runs by repeated squaring, one
// fraction bit a cycle, then a scale by ln 2 and round half away from zero.
// ----------------------------------------------------------------------------
`default_nettype none

module cnb_ln_ratio
   import cnb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire ln_req_type req,
   output ln_rsp_type      rsp
);

   typedef enum logic [1:0] {L_IDLE, L_SQ, L_MUL, L_RND} lstate_type;

   lstate_type                    state_ff;
   logic                          phase_ff;
   logic [4:0]                    iter_ff;
   logic [30:0]                   m_ff;
   logic [EXP_BITS-1:0]           e_ff;
   logic [FRAC_BITS-1:0]          frac_ff;
   logic [LOG_BITS-1:0]           lnum_ff;
   logic [LOG_BITS-1:0]           lden_ff;
   logic [LOG_N_BITS-1:0]         den_ff;
   logic [58:0]                   prod_ff;
   logic                          neg_ff;
   logic                          done_ff;
   logic signed [SCORE_BITS-1:0]  value_ff;

   logic [61:0]                   sq;
   logic [31:0]                   m2;
   logic [30:0]                   m_in;
   logic                          bit_in;
   logic [FRAC_BITS-1:0]          frac_in;
   logic signed [LOG_BITS:0]      diff;
   logic [LOG_BITS-1:0]           mag;
   logic [58:0]                   rnd;

   function automatic logic [EXP_BITS-1:0] msb_pos(input logic [LOG_N_BITS-1:0] n);
      msb_pos = '0;
      for (int i = 0; i < LOG_N_BITS; i++) begin
         if (n[i]) msb_pos = EXP_BITS'(i);
      end
   endfunction

   function automatic logic [30:0] norm(input logic [LOG_N_BITS-1:0] n);
      logic [LOG_N_BITS-1:0] nn;
      nn   = (n == '0) ? LOG_N_BITS'(1) : n;
      norm = 31'(nn) << (5'd30 - msb_pos(nn));
   endfunction

   function automatic logic [EXP_BITS-1:0] expo(input logic [LOG_N_BITS-1:0] n);
      expo = msb_pos((n == '0) ? LOG_N_BITS'(1) : n);
   endfunction

   always_comb begin
      sq      = m_ff * m_ff;
      m2      = sq[61:30];
      bit_in  = m2[31];
      m_in    = m2[31] ? m2[31:1] : m2[30:0];
      frac_in = {frac_ff[FRAC_BITS-2:0], bit_in};
      diff    = $signed({1'b0, lnum_ff}) - $signed({1'b0, lden_ff});
      mag     = diff[LOG_BITS] ? LOG_BITS'(-diff) : diff[LOG_BITS-1:0];
      rnd     = (prod_ff + (59'(1) << 37)) >> 38;
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= L_IDLE;
      end else begin
         case (state_ff)
            L_IDLE: begin
               if (req.start) begin
                  m_ff     <= norm(req.num);
                  e_ff     <= expo(req.num);
                  den_ff   <= req.den;
                  phase_ff <= 1'b0;
                  iter_ff  <= '0;
                  state_ff <= L_SQ;
               end
            end
            L_SQ: begin
               frac_ff <= frac_in;
               m_ff    <= m_in;
               iter_ff <= iter_ff + 5'd1;
               if (iter_ff == 5'(FRAC_BITS - 1)) begin
                  iter_ff <= '0;
                  if (!phase_ff) begin
                     lnum_ff  <= {e_ff, frac_in};
                     m_ff     <= norm(den_ff);
                     e_ff     <= expo(den_ff);
                     phase_ff <= 1'b1;
                  end else begin
                     lden_ff  <= {e_ff, frac_in};
                     state_ff <= L_MUL;
                  end
               end
            end
            L_MUL: begin
               prod_ff  <= 59'(mag) * 59'(LN2_Q30);
               neg_ff   <= diff[LOG_BITS];
               state_ff <= L_RND;
            end
            L_RND: begin
               value_ff <= neg_ff ? -$signed(SCORE_BITS'(rnd)) : $signed(SCORE_BITS'(rnd));
               done_ff  <= 1'b1;
               state_ff <= L_IDLE;
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.value = value_ff;

endmodule

`default_nettype wire

// ----- sv/cnb_checker.sv -----
// ----------------------------------------------------------------------------
// cnb_checker
// Port-level checks of the classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cnb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_class,
   input wire logic        rsp_found,
   input wire logic [31:0] rsp_score
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_score) && $stable(rsp_class))
      else $error("rsp payload changed while stalled");

   a_no_answer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_class == 3'd0 && rsp_score == 32'd0)
      else $error("untrained result carries data");

   a_sweep: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("req ready during clearing sweep");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken again before previous beat decoded");

endmodule

bind categorical_naive_bayes_top cnb_checker u_cnb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_class (rsp_ch.predicted_class),
   .rsp_found (rsp_ch.found),
   .rsp_score (rsp_ch.best_score)
);

`default_nettype wire
